FILE: hdl/aco_pkg.sv
// Shared types and constants for the alpha "over" compositing block.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package aco_pkg;

   localparam int unsigned ACO_MAX_DIM   = 4096;
   localparam int unsigned ACO_LATENCY   = 3;
   localparam int unsigned ACO_CSR_IDX_W = 3;
   localparam int unsigned ACO_CSR_DAT_W = 13;
   localparam int unsigned ACO_REQ_W     = 88;
   localparam int unsigned ACO_RSP_W     = 32;
   localparam int unsigned ACO_CNT_W     = 3;

   localparam logic [7:0] ACO_ALPHA_FULL = 8'd255;
   localparam logic [7:0] ACO_ALPHA_COPY = 8'd254;
   localparam logic [7:0] ACO_ROUND      = 8'd127;

   typedef enum logic [ACO_CSR_IDX_W-1:0] {
      CSR_OPACITY    = 3'd0,
      CSR_X_OFFSET   = 3'd1,
      CSR_Y_OFFSET   = 3'd2,
      CSR_SRC_WIDTH  = 3'd3,
      CSR_SRC_HEIGHT = 3'd4,
      CSR_DST_WIDTH  = 3'd5,
      CSR_DST_HEIGHT = 3'd6
   } csr_index_type;

endpackage

`default_nettype wire

FILE: hdl/alpha_composite_over_unit.sv
// Alpha "over" compositing of one RGBA8 pixel per item inside a clipped rectangle.
// Depends on aco_pkg for constants and register indexes.
// Throughput: one item per cycle while rsp_tready does not stall; three register stages
// (rectangle test and alpha scale, channel multiplies, sum and select) each hold their own valid bit.
// Reset: synchronous; clears stage valid bits and loads register reset values.
`default_nettype none

module alpha_composite_over_unit #(
   parameter int unsigned MAX_DIM = aco_pkg::ACO_MAX_DIM
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // pix_x[11:0], pix_y[23:12], src_red, src_green, src_blue, src_alpha,
   // dst_red, dst_green, dst_blue, dst_alpha (8 bits each, from bit 24 up)
   input  wire logic [aco_pkg::ACO_REQ_W-1:0]       req_tdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
   output logic [aco_pkg::ACO_RSP_W-1:0]            rsp_tdata,
   // was_written[0]
   output logic                                     rsp_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   input  wire logic                                csr_we,
   input  wire logic [aco_pkg::ACO_CSR_IDX_W-1:0]   csr_index,
   input  wire logic [aco_pkg::ACO_CSR_DAT_W-1:0]   csr_wdata
);
   import aco_pkg::*;

   localparam logic [12:0] DIM_CAP = (MAX_DIM > 8191) ? 13'(8191) : 13'(MAX_DIM);

   logic [7:0]         opacity_ff;
   logic signed [12:0] x_off_ff, y_off_ff;
   logic [12:0]        src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [12:0]        dim_in;

   always_comb begin
      dim_in = (csr_wdata > DIM_CAP) ? DIM_CAP : csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opacity_ff <= ACO_ALPHA_FULL;
         x_off_ff   <= '0;
         y_off_ff   <= '0;
         src_w_ff   <= '0;
         src_h_ff   <= '0;
         dst_w_ff   <= '0;
         dst_h_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OPACITY:    opacity_ff <= csr_wdata[7:0];
            CSR_X_OFFSET:   x_off_ff   <= signed'(csr_wdata);
            CSR_Y_OFFSET:   y_off_ff   <= signed'(csr_wdata);
            CSR_SRC_WIDTH:  src_w_ff   <= dim_in;
            CSR_SRC_HEIGHT: src_h_ff   <= dim_in;
            CSR_DST_WIDTH:  dst_w_ff   <= dim_in;
            CSR_DST_HEIGHT: dst_h_ff   <= dim_in;
            default: ;
         endcase
      end
   end

   // stage handshake
   logic v1_ff, v2_ff, v3_ff;
   logic rdy1, rdy2, rdy3;

   always_comb begin
      rdy3       = !v3_ff || rsp_tready;
      rdy2       = !v2_ff || rdy3;
      rdy1       = !v1_ff || rdy2;
      req_tready = rdy1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: rectangle test and effective alpha
   logic [11:0]        px, py;
   logic [7:0]         s_in [3], d_in [4];
   logic [7:0]         sa_in;
   logic signed [14:0] px_s, py_s, xo_s, yo_s, xhi_s, yhi_s;
   logic               inside_in;
   logic [15:0]        alpha_prod;
   logic [7:0]         a1_in;

   always_comb begin
      px    = req_tdata[11:0];
      py    = req_tdata[23:12];
      s_in[0] = req_tdata[31:24];
      s_in[1] = req_tdata[39:32];
      s_in[2] = req_tdata[47:40];
      sa_in   = req_tdata[55:48];
      d_in[0] = req_tdata[63:56];
      d_in[1] = req_tdata[71:64];
      d_in[2] = req_tdata[79:72];
      d_in[3] = req_tdata[87:80];
      px_s  = signed'({3'b000, px});
      py_s  = signed'({3'b000, py});
      xo_s  = {{2{x_off_ff[12]}}, x_off_ff};
      yo_s  = {{2{y_off_ff[12]}}, y_off_ff};
      xhi_s = xo_s + signed'({2'b00, src_w_ff});
      yhi_s = yo_s + signed'({2'b00, src_h_ff});
      inside_in = (px_s >= xo_s) && (px_s < xhi_s) && (px_s < signed'({2'b00, dst_w_ff}))
               && (py_s >= yo_s) && (py_s < yhi_s) && (py_s < signed'({2'b00, dst_h_ff}));
      alpha_prod = 16'(sa_in * opacity_ff) + {8'd0, ACO_ROUND};
      a1_in      = alpha_prod[15:8];
   end

   logic [7:0] s1_ff [3], d1_ff [4];
   logic [7:0] a1_ff;
   logic       inside1_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff      <= s_in;
         d1_ff      <= d_in;
         a1_ff      <= a1_in;
         inside1_ff <= inside_in;
      end
   end

   // stage 2: channel products
   logic [7:0]  inv;
   logic [15:0] ps_in [3], pd_in [4];

   always_comb begin
      inv = ACO_ALPHA_FULL - a1_ff;
      for (int c = 0; c < 3; c++) begin
         ps_in[c] = 16'(s1_ff[c] * a1_ff);
      end
      for (int c = 0; c < 4; c++) begin
         pd_in[c] = 16'(d1_ff[c] * inv);
      end
   end

   logic [7:0]  s2_ff [3], d2_ff [4];
   logic [15:0] ps2_ff [3], pd2_ff [4];
   logic [7:0]  a2_ff;
   logic        hit2_ff, copy2_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_ff    <= s1_ff;
         d2_ff    <= d1_ff;
         ps2_ff   <= ps_in;
         pd2_ff   <= pd_in;
         a2_ff    <= a1_ff;
         hit2_ff  <= inside1_ff && (a1_ff != 8'd0);
         copy2_ff <= a1_ff >= ACO_ALPHA_COPY;
      end
   end

   // stage 3: sum, shift and select
   logic [7:0]  o_in [4];
   logic [16:0] mix;

   always_comb begin
      mix = '0;
      for (int c = 0; c < 3; c++) begin
         mix = {1'b0, ps2_ff[c]} + {1'b0, pd2_ff[c]};
         if (!hit2_ff) begin
            o_in[c] = d2_ff[c];
         end else if (copy2_ff) begin
            o_in[c] = s2_ff[c];
         end else begin
            o_in[c] = mix[15:8];
         end
      end
      if (!hit2_ff) begin
         o_in[3] = d2_ff[3];
      end else if (copy2_ff) begin
         o_in[3] = ACO_ALPHA_FULL;
      end else begin
         o_in[3] = a2_ff + pd2_ff[3][15:8];
      end
   end

   logic [ACO_RSP_W-1:0] rsp_data_ff;
   logic                 rsp_user_ff;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         rsp_data_ff <= {o_in[3], o_in[2], o_in[1], o_in[0]};
         rsp_user_ff <= hit2_ff;
      end
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tvalid = v3_ff;

endmodule

`default_nettype wire

FILE: hdl/aco_checker.sv
// Port-level checks for alpha_composite_over_unit, bound to the top level.
// Depends on aco_pkg for latency and counter width.
`default_nettype none

module aco_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [aco_pkg::ACO_RSP_W-1:0]  rsp_tdata,
   input wire logic                           rsp_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready
);
   import aco_pkg::*;

   logic                 req_acc, rsp_acc;
   logic [ACO_CNT_W-1:0] count_ff, count_in;

   always_comb begin
      req_acc  = req_tvalid && req_tready;
      rsp_acc  = rsp_tvalid && rsp_tready;
      count_in = count_ff + ACO_CNT_W'(req_acc) - ACO_CNT_W'(rsp_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp item changed");

   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !rsp_tvalid)
      else $error("rsp item without a req item");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ACO_CNT_W'(ACO_LATENCY))
      else $error("more items in flight than stages");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_acc && (count_ff == '0) |-> ##3 rsp_tvalid)
      else $error("item not delivered after pipeline latency");

endmodule

bind alpha_composite_over_unit aco_checker u_aco_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

FILE: test/testbench.sv
// Self-checking bench for alpha_composite_over_unit: clipped "over" blending of RGBA8 pixels.
// Drives the pixel and register ports, predicts each result in place and checks it.
// Needs aco_pkg and the unit itself.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import aco_pkg::*;

   localparam logic [ACO_CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct {
      logic [11:0] x;
      logic [11:0] y;
      logic [7:0]  src_r, src_g, src_b, src_a;
      logic [7:0]  dst_r, dst_g, dst_b, dst_a;
   } pixel_type;

   typedef struct {
      logic [7:0] red, green, blue, alpha;
      logic       written;
   } blended_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic [ACO_REQ_W-1:0]     req_tdata = '0;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ACO_RSP_W-1:0]     rsp_tdata;
   logic                     rsp_tuser;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic                     csr_we = 1'b0;
   logic [ACO_CSR_IDX_W-1:0] csr_index = '0;
   logic [ACO_CSR_DAT_W-1:0] csr_wdata = '0;

   // layer registers as the unit should hold them
   logic [7:0] opacity;
   int         x_off, y_off, src_w, src_h, dst_w, dst_h;

   blended_type pending_pixels[$];
   bit          steady = 1'b0;
   int          error_count = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          written_count = 0;

   alpha_composite_over_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 11);
   end

   function automatic int span_lo(input int off);
      return (off > 0) ? off : 0;
   endfunction

   function automatic int span_hi(input int off, input int slen, input int dlen);
      return (off + slen < dlen) ? off + slen : dlen;
   endfunction

   function automatic bit covers(input int p, input int off, input int slen, input int dlen);
      return p >= span_lo(off) && p < span_hi(off, slen, dlen);
   endfunction

   function automatic blended_type blend_pixel(input pixel_type p);
      blended_type res;
      int unsigned a;
      int unsigned inv;
      res = '{p.dst_r, p.dst_g, p.dst_b, p.dst_a, 1'b0};
      if (!covers(int'(p.x), x_off, src_w, dst_w) || !covers(int'(p.y), y_off, src_h, dst_h))
         return res;
      a = (int'(p.src_a) * int'(opacity) + int'(ACO_ROUND)) >> 8;
      if (a > ACO_ALPHA_FULL)
         a = ACO_ALPHA_FULL;
      if (a == 0)
         return res;
      if (a >= ACO_ALPHA_COPY) begin
         res = '{p.src_r, p.src_g, p.src_b, ACO_ALPHA_FULL, 1'b1};
      end else begin
         inv = ACO_ALPHA_FULL - a;
         res.red     = 8'((int'(p.src_r) * a + int'(p.dst_r) * inv) >> 8);
         res.green   = 8'((int'(p.src_g) * a + int'(p.dst_g) * inv) >> 8);
         res.blue    = 8'((int'(p.src_b) * a + int'(p.dst_b) * inv) >> 8);
         res.alpha   = 8'(a + ((int'(p.dst_a) * inv) >> 8));
         res.written = 1'b1;
      end
      return res;
   endfunction

   function automatic int clamp_dim(input logic [ACO_CSR_DAT_W-1:0] value);
      return (value > ACO_MAX_DIM) ? ACO_MAX_DIM : int'(value);
   endfunction

   function automatic pixel_type make_pixel(input int x, input int y, input logic [7:0] sa,
                                            input logic [7:0] fill);
      pixel_type p;
      p = '{12'(x), 12'(y), fill, ~fill, fill ^ 8'h5a, sa, ~fill, fill, fill ^ 8'ha5, ~sa};
      return p;
   endfunction

   task automatic write_reg(input logic [ACO_CSR_IDX_W-1:0] idx,
                            input logic [ACO_CSR_DAT_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_OPACITY:    opacity = value[7:0];
         CSR_X_OFFSET:   x_off = int'($signed(value));
         CSR_Y_OFFSET:   y_off = int'($signed(value));
         CSR_SRC_WIDTH:  src_w = clamp_dim(value);
         CSR_SRC_HEIGHT: src_h = clamp_dim(value);
         CSR_DST_WIDTH:  dst_w = clamp_dim(value);
         CSR_DST_HEIGHT: dst_h = clamp_dim(value);
         default: ;
      endcase
   endtask

   task automatic end_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_layer(input int op, input int xo, input int yo, input int sw,
                            input int sh, input int dw, input int dh);
      write_reg(CSR_OPACITY, 13'(op));
      write_reg(CSR_X_OFFSET, 13'(xo));
      write_reg(CSR_Y_OFFSET, 13'(yo));
      write_reg(CSR_SRC_WIDTH, 13'(sw));
      write_reg(CSR_SRC_HEIGHT, 13'(sh));
      write_reg(CSR_DST_WIDTH, 13'(dw));
      write_reg(CSR_DST_HEIGHT, 13'(dh));
      end_writes();
   endtask

   task automatic send_pixel(input pixel_type p);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {p.dst_a, p.dst_b, p.dst_g, p.dst_r,
                     p.src_a, p.src_b, p.src_g, p.src_r, p.y, p.x};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      pending_pixels.push_back(blend_pixel(p));
      items_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (ACO_LATENCY + 2) @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      blended_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_pixels.size() == 0) begin
            error_count++;
            $display("%0t ns: unexpected item, expected none, got data %h user %b",
                     $time, rsp_tdata, rsp_tuser);
         end else begin
            want = pending_pixels.pop_front();
            check_field("out_red", want.red, rsp_tdata[7:0]);
            check_field("out_green", want.green, rsp_tdata[15:8]);
            check_field("out_blue", want.blue, rsp_tdata[23:16]);
            check_field("out_alpha", want.alpha, rsp_tdata[31:24]);
            check_field("was_written", 8'(want.written), 8'(rsp_tuser));
            results_checked++;
            if (want.written)
               written_count++;
         end
      end
   end

   task automatic test_reset_values();
      opacity = ACO_ALPHA_FULL;
      x_off = 0;
      y_off = 0;
      src_w = 0;
      src_h = 0;
      dst_w = 0;
      dst_h = 0;
      send_pixel(make_pixel(0, 0, 8'hff, 8'h00));
      send_pixel(make_pixel(4095, 4095, 8'hff, 8'hff));
      send_pixel(make_pixel(1, 2, 8'h80, 8'h3c));
      drain();
   endtask

   task automatic test_full_layer();
      set_layer(255, 0, 0, 4096, 4096, 4096, 4096);
      send_pixel(make_pixel(0, 0, 8'hff, 8'h00));
      send_pixel(make_pixel(4095, 4095, 8'hff, 8'hff));
      send_pixel(make_pixel(100, 7, 8'h00, 8'h5a));
      send_pixel(make_pixel(2048, 2048, 8'h80, 8'hc3));
      send_pixel(make_pixel(3, 4000, 8'h01, 8'hff));
      send_pixel(make_pixel(4000, 3, 8'hfe, 8'h00));
      drain();
   endtask

   task automatic test_opacity();
      set_layer(0, 0, 0, 64, 64, 64, 64);
      send_pixel(make_pixel(5, 5, 8'hff, 8'h96));
      drain();
      write_reg(CSR_OPACITY, 13'd1);
      end_writes();
      send_pixel(make_pixel(6, 6, 8'hff, 8'h69));
      drain();
      write_reg(CSR_OPACITY, 13'd128);
      end_writes();
      send_pixel(make_pixel(7, 7, 8'h01, 8'h12));
      send_pixel(make_pixel(8, 8, 8'hff, 8'hed));
      drain();
   endtask

   task automatic test_clip_edges();
      set_layer(255, 10, -5, 20, 20, 25, 4096);
      send_pixel(make_pixel(9, 0, 8'hff, 8'h11));
      send_pixel(make_pixel(10, 0, 8'hff, 8'h22));
      send_pixel(make_pixel(24, 14, 8'h90, 8'h33));
      send_pixel(make_pixel(25, 5, 8'hff, 8'h44));
      send_pixel(make_pixel(12, 15, 8'hff, 8'h55));
      drain();
      // oversized dimensions clamp, far-left layer is empty
      set_layer(255, -4096, 4095, 8191, 4097, 8191, 4096);
      send_pixel(make_pixel(0, 4095, 8'hff, 8'h66));
      drain();
      write_reg(CSR_X_OFFSET, 13'd4095);
      write_reg(CSR_SRC_WIDTH, 13'd1);
      write_reg(CSR_UNMAPPED, 13'h1fff);
      end_writes();
      send_pixel(make_pixel(4095, 4095, 8'hff, 8'h77));
      send_pixel(make_pixel(4094, 4095, 8'hff, 8'h88));
      drain();
   endtask

   function automatic int pick_offset();
      int r;
      r = $urandom_range(99);
      if (r < 10) return -4096;
      if (r < 20) return 4095;
      if (r < 35) return int'($signed(13'($urandom_range(8191))));
      return int'($urandom_range(200)) - 50;
   endfunction

   function automatic int pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(8191, ACO_MAX_DIM + 1);
      if (r < 25) return ACO_MAX_DIM;
      if (r < 30) return 0;
      return $urandom_range(300);
   endfunction

   function automatic int pick_opacity();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 0;
      if (r < 30) return 255;
      if (r < 40) return 1;
      return $urandom_range(255);
   endfunction

   function automatic logic [11:0] pick_coord(input int lo, input int hi);
      int r;
      int c;
      r = $urandom_range(99);
      if (hi > lo && r < 70)
         return 12'($urandom_range(hi - 1, lo));
      if (r < 85) begin
         c = (r < 78) ? lo - 1 : hi;
         if (c < 0) c = 0;
         if (c > 4095) c = 4095;
         return 12'(c);
      end
      return 12'($urandom_range(4095));
   endfunction

   function automatic logic [7:0] pick_alpha();
      int r;
      r = $urandom_range(99);
      if (r < 15) return 8'h00;
      if (r < 30) return 8'hff;
      if (r < 35) return 8'hfe;
      if (r < 40) return 8'h01;
      return 8'($urandom_range(255));
   endfunction

   function automatic pixel_type random_pixel();
      pixel_type p;
      p.x     = pick_coord(span_lo(x_off), span_hi(x_off, src_w, dst_w));
      p.y     = pick_coord(span_lo(y_off), span_hi(y_off, src_h, dst_h));
      p.src_r = 8'($urandom_range(255));
      p.src_g = 8'($urandom_range(255));
      p.src_b = 8'($urandom_range(255));
      p.src_a = pick_alpha();
      p.dst_r = 8'($urandom_range(255));
      p.dst_g = 8'($urandom_range(255));
      p.dst_b = 8'($urandom_range(255));
      p.dst_a = 8'($urandom_range(255));
      return p;
   endfunction

   task automatic test_random_layers();
      for (int phase = 0; phase < 10; phase++) begin
         set_layer(pick_opacity(), pick_offset(), pick_offset(),
                   pick_dim(), pick_dim(), pick_dim(), pick_dim());
         steady = (phase == 4);
         for (int n = 0; n < 110; n++)
            send_pixel(random_pixel());
         drain();
         steady = 1'b0;
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_full_layer();
      test_opacity();
      test_clip_edges();
      test_random_layers();
      $display("Sent %0d pixels over 18 layer settings; checked %0d results, %0d written.",
               items_sent, results_checked, written_count);
      if (error_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Run stopped by timeout with %0d results still due.", pending_pixels.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire
